// ===== sv/imm_pkg.sv =====
// Package for the 16-bit integer matrix multiply block.
// Holds field widths, action and register codes and the MAC control struct.
// No dependencies; every other file of the block imports it.
`default_nettype none

package imm_pkg;

    localparam int ActionW  = 2;
    localparam int IndexW   = 12;
    localparam int DataW    = 16;
    localparam int DimW     = 7;
    localparam int CfgIdxW  = 2;
    localparam int RcW      = 6;
    localparam int StoreAw  = 12;
    localparam int MaxCols  = 64;

    localparam logic [ActionW-1:0] ActWriteA  = 2'd0;
    localparam logic [ActionW-1:0] ActWriteB  = 2'd1;
    localparam logic [ActionW-1:0] ActCompute = 2'd2;

    localparam logic [CfgIdxW-1:0] CfgRowsA    = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgInnerLen = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgColsB    = 2'd2;

    localparam logic [DimW-1:0] DimReset = 7'd64;

    typedef logic [DataW-1:0] t_data;

    typedef struct packed {
        logic issue;
        logic clear;
    } t_mac_ctrl;

endpackage

`default_nettype wire

// ===== sv/imm_in_if.sv =====
// Input channel of the matrix multiply block: action, index and value.
// Depends on imm_pkg for the field widths.
`default_nettype none

interface imm_in_if
    import imm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ActionW-1:0] action;
    logic [IndexW-1:0]  index;
    logic [DataW-1:0]   value;

    modport source (output valid, output action, output index, output value, input ready);
    modport sink   (input valid, input action, input index, input value, output ready);
endinterface

`default_nettype wire

// ===== sv/imm_out_if.sv =====
// Result channel of the matrix multiply block: one element of a row of C.
// Depends on imm_pkg for the field widths.
`default_nettype none

interface imm_out_if
    import imm_pkg::*;
();
    logic           valid;
    logic           ready;
    logic [RcW-1:0] row;
    logic [RcW-1:0] col;
    logic [DataW-1:0] product;
    logic           last;
    logic           error;

    modport source (output valid, output row, output col, output product,
                    output last, output error, input ready);
    modport sink   (input valid, input row, input col, input product,
                    input last, input error, output ready);
endinterface

`default_nettype wire

// ===== sv/imm_cfg_if.sv =====
// Configuration write channel of the matrix multiply block.
// Depends on imm_pkg for the register index and data widths.
`default_nettype none

interface imm_cfg_if
    import imm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [DimW-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/imm_store.sv =====
// Element stores for matrices A and B, 4096 x 16 bits each, registered read.
// Depends on imm_pkg.
`default_nettype none

module imm_store
    import imm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_wr_a,
    input  wire logic               i_wr_b,
    input  wire logic [StoreAw-1:0] i_wr_addr,
    input  wire t_data              i_wr_data,
    input  wire logic               i_rd_en,
    input  wire logic [StoreAw-1:0] i_rd_addr_a,
    input  wire logic [StoreAw-1:0] i_rd_addr_b,
    output      t_data              o_rd_a,
    output      t_data              o_rd_b
);

    localparam int Depth = 1 << StoreAw;

    t_data r_mem_a [Depth];
    t_data r_mem_b [Depth];
    t_data r_rd_a;
    t_data r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_a) begin
            r_mem_a[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem_a[i_rd_addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_b) begin
            r_mem_b[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_b <= r_mem_b[i_rd_addr_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

`default_nettype wire

// ===== sv/imm_mac.sv =====
// Shared multiply-accumulate unit: a registered 16x16 product feeding a
// 16-bit wrapping accumulator. Depends on imm_pkg.
`default_nettype none

module imm_mac
    import imm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_mac_ctrl i_ctrl,
    input  wire t_data     i_a,
    input  wire t_data     i_b,
    output      logic      o_busy,
    output      t_data     o_acc
);

    logic               r_s1_vld;
    logic               r_s2_vld;
    logic [2*DataW-1:0] w_full;
    t_data              r_prod;
    t_data              r_acc;

    // Only the low half of the product survives the 16-bit wrap, and the
    // low half is the same for signed and unsigned operands.
    assign w_full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_ctrl.issue;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_prod <= w_full[DataW-1:0];
        end
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (r_s2_vld) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_busy = r_s1_vld | r_s2_vld;
    assign o_acc  = r_acc;

endmodule

`default_nettype wire

// ===== sv/int16_matrix_multiply.sv =====
// Integer matrix multiply C = A x B on 16-bit signed entries, 16-bit wrap.
// Input channel i_in: action 0 writes A[index], action 1 writes B[index]
// (flat row-major, 4096 entries each), action 2 computes row index of C,
// action 3 is ignored. Writes give no result.
// A compute gives cols_b transactions on o_out, one per column, with last
// set on the final one; a row at or beyond rows_a gives one transaction
// with error and last set and the other fields zero.
// Configuration channel i_cfg writes rows_a (0), inner_len (1), cols_b (2);
// it is always ready. The user must see that it is written only while the
// block is idle; the block itself does not enforce this.
// Sequence: one multiplier is shared by all multiply-accumulates. For each
// column a compute issues inner_len store reads, drains the read and
// multiply stages, then loads the result register. i_in is not ready until
// the compute ends, and a stall on o_out lengthens the compute. The result
// register holds its transaction while o_out.ready is low, and the
// sequencer waits for it before loading the next column.
// Reset (synchronous, active low) sets all three dimensions to 64 and
// empties the result register. Store contents are undefined until written.
`default_nettype none

module int16_matrix_multiply
    import imm_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    imm_in_if.sink    i_in,
    imm_cfg_if.sink   i_cfg,
    imm_out_if.source o_out
);

    localparam int DimCap = (MAX_DIM > 127) ? 127 : MAX_DIM;
    localparam int ColCap = (DimCap > MaxCols) ? MaxCols : DimCap;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]         r_state;
    logic [DimW-1:0]    r_rows_a;
    logic [DimW-1:0]    r_inner_len;
    logic [DimW-1:0]    r_cols_b;
    logic [IndexW-1:0]  r_idx;
    logic [StoreAw-1:0] r_base;
    logic [StoreAw-1:0] r_a_addr;
    logic [StoreAw-1:0] r_b_addr;
    logic [DimW-1:0]    r_k;
    logic [RcW-1:0]     r_j;
    logic               r_err;

    logic               r_o_valid;
    logic [RcW-1:0]     r_o_row;
    logic [RcW-1:0]     r_o_col;
    t_data              r_o_product;
    logic               r_o_last;
    logic               r_o_error;

    logic [DimW-1:0]    w_nr;
    logic [DimW-1:0]    w_nk;
    logic [DimW-1:0]    w_nc;
    logic               w_in_acc;
    logic               w_row_bad;
    logic [StoreAw-1:0] n_base;
    logic               w_col_last;
    logic               w_load;
    logic               w_mac_busy;
    t_data              w_acc;
    t_data              w_rd_a;
    t_data              w_rd_b;
    t_mac_ctrl          w_mac_ctrl;

    // Register values above the cap count as the cap.
    assign w_nr = (r_rows_a > DimW'(DimCap)) ? DimW'(DimCap) : r_rows_a;
    assign w_nk = (r_inner_len > DimW'(DimCap)) ? DimW'(DimCap) : r_inner_len;
    assign w_nc = (r_cols_b > DimW'(ColCap)) ? DimW'(ColCap) : r_cols_b;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;

    assign w_row_bad  = r_idx >= IndexW'(w_nr);
    assign n_base     = StoreAw'(r_idx * IndexW'(w_nk));
    assign w_col_last = (DimW'(r_j) + DimW'(1)) == w_nc;
    assign w_load     = (r_state == S_OUT) && (!r_o_valid || o_out.ready);

    assign w_mac_ctrl.issue = (r_state == S_ISSUE);
    assign w_mac_ctrl.clear = w_load || (r_state == S_START);

    imm_store u_store (
        .i_clk       (i_clk),
        .i_wr_a      (w_in_acc && (i_in.action == ActWriteA)),
        .i_wr_b      (w_in_acc && (i_in.action == ActWriteB)),
        .i_wr_addr   (i_in.index),
        .i_wr_data   (i_in.value),
        .i_rd_en     (w_mac_ctrl.issue),
        .i_rd_addr_a (r_a_addr),
        .i_rd_addr_b (r_b_addr),
        .o_rd_a      (w_rd_a),
        .o_rd_b      (w_rd_b)
    );

    imm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_mac_ctrl),
        .i_a     (w_rd_a),
        .i_b     (w_rd_b),
        .o_busy  (w_mac_busy),
        .o_acc   (w_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= DimReset;
            r_inner_len <= DimReset;
            r_cols_b    <= DimReset;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CfgRowsA:    r_rows_a    <= i_cfg.data;
                CfgInnerLen: r_inner_len <= i_cfg.data;
                CfgColsB:    r_cols_b    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (i_in.action == ActCompute)) begin
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    if (w_row_bad) begin
                        r_state <= S_OUT;
                    end else if (w_nc == '0) begin
                        r_state <= S_IDLE;
                    end else if (w_nk == '0) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if ((r_k + DimW'(1)) == w_nk) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!w_mac_busy) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        if (r_err || w_col_last) begin
                            r_state <= S_IDLE;
                        end else if (w_nk == '0) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_state <= S_ISSUE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Address walk: A runs along row idx, B steps down column j by cols_b.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_idx <= i_in.index;
                end
            end
            S_START: begin
                r_err    <= w_row_bad;
                r_base   <= n_base;
                r_a_addr <= n_base;
                r_b_addr <= '0;
                r_k      <= '0;
                r_j      <= '0;
            end
            S_ISSUE: begin
                r_a_addr <= r_a_addr + StoreAw'(1);
                r_b_addr <= r_b_addr + StoreAw'(w_nc);
                r_k      <= r_k + DimW'(1);
            end
            S_OUT: begin
                if (w_load) begin
                    r_a_addr <= r_base;
                    r_b_addr <= StoreAw'(r_j) + StoreAw'(1);
                    r_k      <= '0;
                    r_j      <= r_j + RcW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_row     <= r_err ? '0 : r_idx[RcW-1:0];
            r_o_col     <= r_err ? '0 : r_j;
            r_o_product <= r_err ? '0 : w_acc;
            r_o_last    <= r_err | w_col_last;
            r_o_error   <= r_err;
        end
    end

    assign o_out.valid   = r_o_valid;
    assign o_out.row     = r_o_row;
    assign o_out.col     = r_o_col;
    assign o_out.product = r_o_product;
    assign o_out.last    = r_o_last;
    assign o_out.error   = r_o_error;

endmodule

`default_nettype wire

// ===== verif/imm_row_checker.sv =====
`timescale 1ns / 100ps
// Checker for int16_matrix_multiply: watches the input, configuration and result channels,
// predicts every element of C that the block must send and compares it on arrival.
// Depends on imm_pkg and on the interfaces imm_in_if, imm_cfg_if and imm_out_if.
module imm_row_checker
    import imm_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    imm_in_if    i_in_ch,
    imm_cfg_if   i_cfg_ch,
    imm_out_if   i_out_ch,
    output int   o_error_count,
    output int   o_pending
);

    localparam int StoreDepth = 1 << StoreAw;

    typedef struct packed {
        logic [RcW-1:0] row;
        logic [RcW-1:0] col;
        t_data          product;
        logic           last;
        logic           error;
    } t_elem;

    t_data           a_mem [StoreDepth];
    t_data           b_mem [StoreDepth];
    logic [DimW-1:0] rows_a_q;
    logic [DimW-1:0] inner_len_q;
    logic [DimW-1:0] cols_b_q;
    t_elem           expected_elems [$];

    function automatic int unsigned clamp_dim(input logic [DimW-1:0] v, input int unsigned lim);
        return (v > lim) ? lim : int'(v);
    endfunction

    // Works out the row of C that a compute asks for, or applies a store write.
    task automatic predict_row_elems(input logic [ActionW-1:0] act,
                                     input logic [IndexW-1:0] idx, input t_data val);
        int unsigned        nr;
        int unsigned        nk;
        int unsigned        nc;
        t_elem              e;
        t_data              acc;
        logic signed [31:0] prod;
        logic [StoreAw-1:0] a_addr;
        logic [StoreAw-1:0] b_addr;
        nr = clamp_dim(rows_a_q, MAX_DIM);
        nk = clamp_dim(inner_len_q, MAX_DIM);
        nc = clamp_dim(cols_b_q, MAX_DIM);
        if (nc > MaxCols) nc = MaxCols;
        case (act)
            ActWriteA: a_mem[idx] = val;
            ActWriteB: b_mem[idx] = val;
            ActCompute: begin
                if (idx >= nr) begin
                    e = '0;
                    e.last  = 1'b1;
                    e.error = 1'b1;
                    expected_elems.push_back(e);
                end else begin
                    for (int unsigned j = 0; j < nc; j++) begin
                        acc = '0;
                        for (int unsigned k = 0; k < nk; k++) begin
                            a_addr = StoreAw'(idx * nk + k);
                            b_addr = StoreAw'(k * nc + j);
                            prod = $signed(a_mem[a_addr]) * $signed(b_mem[b_addr]);
                            acc = acc + prod[DataW-1:0];
                        end
                        e.row     = RcW'(idx);
                        e.col     = RcW'(j);
                        e.product = acc;
                        e.last    = (j + 1 == nc);
                        e.error   = 1'b0;
                        expected_elems.push_back(e);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_elem();
        t_elem got;
        t_elem want;
        got.row     = i_out_ch.row;
        got.col     = i_out_ch.col;
        got.product = i_out_ch.product;
        got.last    = i_out_ch.last;
        got.error   = i_out_ch.error;
        if (expected_elems.size() == 0) begin
            $display("%0t: unexpected element: expected none, actual row %0d col %0d",
                     $time, got.row, got.col,
                     " product %h last %b error %b", got.product, got.last, got.error);
            o_error_count++;
        end else begin
            want = expected_elems.pop_front();
            if (got !== want) begin
                $display("%0t: mismatch: expected row %0d col %0d product %h last %b error %b,",
                         $time, want.row, want.col, want.product, want.last, want.error,
                         " actual row %0d col %0d product %h last %b error %b",
                         got.row, got.col, got.product, got.last, got.error);
                o_error_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_a_q      = DimReset;
            inner_len_q   = DimReset;
            cols_b_q      = DimReset;
            o_error_count = 0;
            expected_elems.delete();
        end else begin
            if (i_out_ch.valid && i_out_ch.ready) check_elem();
            if (i_cfg_ch.valid && i_cfg_ch.ready) begin
                case (i_cfg_ch.index)
                    CfgRowsA:    rows_a_q    = i_cfg_ch.data;
                    CfgInnerLen: inner_len_q = i_cfg_ch.data;
                    CfgColsB:    cols_b_q    = i_cfg_ch.data;
                    default: ;
                endcase
            end
            if (i_in_ch.valid && i_in_ch.ready)
                predict_row_elems(i_in_ch.action, i_in_ch.index, i_in_ch.value);
        end
        o_pending = expected_elems.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for int16_matrix_multiply: clock, reset, stimulus and the final verdict.
// Depends on imm_pkg, the channel interfaces, the block itself and imm_row_checker.
module tb;
    import imm_pkg::*;

    localparam logic [ActionW-1:0] ActIgnored = 2'd3;
    localparam logic [CfgIdxW-1:0] CfgUnused  = 2'd3;
    localparam int MaxDim        = 64;
    localparam int StoreDepth    = 1 << StoreAw;
    localparam int OpsPerPhase   = 2;
    localparam int IdleTail      = 16;
    localparam int EndTail       = 64;
    localparam int HoldCycles    = 300;
    localparam int NumPhases     = 10;
    localparam int WidePhase     = 1;
    localparam int PressurePhase = 8;
    localparam int RandomPhases  = 2;

    logic i_clk;
    logic i_rst_n;
    int   error_count;
    int   pending;

    imm_in_if  in_ch ();
    imm_cfg_if cfg_ch ();
    imm_out_if out_ch ();

    // Marks store entries that hold a written value, so no compute reads an unwritten one.
    logic        a_loaded [StoreDepth];
    logic        b_loaded [StoreDepth];
    int unsigned n_rows;
    int unsigned n_inner;
    int unsigned n_cols;
    bit          idle_on;
    bit          hold_req;

    int phase_rows  [NumPhases] = '{1, 127, 4, 0, 3, 3, 6, 2, 3, 5};
    int phase_inner [NumPhases] = '{1, 1,   3, 3, 0, 3, 2, 5, 4, 5};
    int phase_cols  [NumPhases] = '{1, 100, 2, 3, 5, 0, 5, 1, 8, 5};

    int16_matrix_multiply #(.MAX_DIM(MaxDim)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    imm_row_checker #(.MAX_DIM(MaxDim)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_ch       (in_ch),
        .i_cfg_ch      (cfg_ch),
        .i_out_ch      (out_ch),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #20_000_000;
        $display("%0t: run timed out", $time);
        $display("** int16_matrix_multiply: FAILED **");
        $finish;
    end

    task automatic send_item(input logic [ActionW-1:0] act, input logic [IndexW-1:0] idx,
                             input t_data val);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid  <= 1'b1;
        in_ch.action <= act;
        in_ch.index  <= idx;
        in_ch.value  <= val;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (act == ActWriteA) a_loaded[idx] = 1'b1;
        if (act == ActWriteB) b_loaded[idx] = 1'b1;
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DimW-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stops offering items until every element has arrived, then lets the block settle.
    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (IdleTail) @(negedge i_clk);
    endtask

    task automatic apply_dims(input int r, input int k, input int c);
        drain_results();
        write_reg(CfgRowsA, DimW'(r));
        write_reg(CfgInnerLen, DimW'(k));
        write_reg(CfgColsB, DimW'(c));
        n_rows  = (r > MaxDim) ? MaxDim : r;
        n_inner = (k > MaxDim) ? MaxDim : k;
        n_cols  = (c > MaxDim) ? MaxDim : c;
    endtask

    // Loads whatever the row still lacks in A and B, then asks for the row.
    task automatic request_row(input int unsigned row);
        logic [StoreAw-1:0] addr;
        if (row < n_rows) begin
            for (int unsigned k = 0; k < n_inner; k++) begin
                addr = StoreAw'(row * n_inner + k);
                if (!a_loaded[addr]) send_item(ActWriteA, addr, t_data'($urandom));
            end
            for (int unsigned k = 0; k < n_inner; k++) begin
                for (int unsigned j = 0; j < n_cols; j++) begin
                    addr = StoreAw'(k * n_cols + j);
                    if (!b_loaded[addr]) send_item(ActWriteB, addr, t_data'($urandom));
                end
            end
        end
        send_item(ActCompute, IndexW'(row), t_data'($urandom));
    endtask

    task automatic random_op();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45 && n_rows > 0)
            request_row($urandom_range(0, n_rows - 1));
        else if (sel < 60 && n_rows * n_inner > 0)
            send_item(ActWriteA, IndexW'($urandom_range(0, n_rows * n_inner - 1)),
                      t_data'($urandom));
        else if (sel < 72 && n_inner * n_cols > 0)
            send_item(ActWriteB, IndexW'($urandom_range(0, n_inner * n_cols - 1)),
                      t_data'($urandom));
        else if (sel < 82)
            send_item($urandom_range(0, 1) ? ActWriteB : ActWriteA,
                      IndexW'($urandom_range(0, StoreDepth - 1)), t_data'($urandom));
        else if (sel < 92)
            request_row($urandom_range(n_rows, StoreDepth - 1));
        else
            send_item(ActIgnored, IndexW'($urandom_range(0, StoreDepth - 1)),
                      t_data'($urandom));
    endtask

    // The long hold is counted here, while the stimulus keeps offering items.
    initial begin : result_sink
        int burst;
        int hold_left;
        burst        = 0;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && hold_left == 0) hold_left = HoldCycles;
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
                if (hold_left == 0) hold_req = 1'b0;
            end else if (burst > 0) begin
                out_ch.ready <= 1'b0;
                burst--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                burst = $urandom_range(0, 3);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.action = ActWriteA;
        in_ch.index  = '0;
        in_ch.value  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CfgRowsA;
        cfg_ch.data  = '0;
        idle_on      = 1'b1;
        hold_req     = 1'b0;
        n_rows       = MaxDim;
        n_inner      = MaxDim;
        n_cols       = MaxDim;
        for (int i = 0; i < StoreDepth; i++) begin
            a_loaded[i] = 1'b0;
            b_loaded[i] = 1'b0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Dimensions out of reset: rows at and far beyond the row count, an unused action,
        // and writes at the ends of the store.
        send_item(ActCompute, IndexW'(64), '0);
        send_item(ActCompute, '1, '1);
        send_item(ActIgnored, '1, 16'h7FFF);
        send_item(ActWriteA, '1, 16'h8000);
        send_item(ActWriteB, '0, 16'h7FFF);
        drain_results();
        write_reg(CfgUnused, '1);

        // A 2x2 product on the extreme values.
        apply_dims(2, 2, 2);
        send_item(ActWriteA, IndexW'(0), 16'h8000);
        send_item(ActWriteA, IndexW'(1), 16'h7FFF);
        send_item(ActWriteA, IndexW'(2), 16'hFFFF);
        send_item(ActWriteA, IndexW'(3), 16'h0000);
        send_item(ActWriteB, IndexW'(0), 16'h8000);
        send_item(ActWriteB, IndexW'(1), 16'h7FFF);
        send_item(ActWriteB, IndexW'(2), 16'h0001);
        send_item(ActWriteB, IndexW'(3), 16'h8000);
        request_row(0);
        request_row(1);
        request_row(2);
        request_row(1);

        for (int p = 0; p < NumPhases; p++) begin
            apply_dims(phase_rows[p], phase_inner[p], phase_cols[p]);
            // A full row of 64 columns, and a row that is valid only without the cap.
            if (p == WidePhase) begin
                request_row(0);
                request_row(100);
            end
            if (p == PressurePhase) begin
                hold_req = 1'b1;
                repeat (4) request_row($urandom_range(0, n_rows - 1));
            end
            repeat (OpsPerPhase) random_op();
        end

        for (int p = 0; p < RandomPhases; p++) begin
            if (p == RandomPhases - 2) idle_on = 1'b0;
            apply_dims($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(1, 8));
            repeat (OpsPerPhase) random_op();
        end

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (EndTail) @(negedge i_clk);
        if (error_count == 0) begin
            $display("** int16_matrix_multiply: PASSED **");
        end else begin
            $display("** int16_matrix_multiply: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/imm_pkg.sv
sv/imm_in_if.sv
sv/imm_out_if.sv
sv/imm_cfg_if.sv
sv/imm_store.sv
sv/imm_mac.sv
sv/int16_matrix_multiply.sv
verif/imm_row_checker.sv
verif/tb.sv
